// ===== rtl/msfp_pkg.sv =====
// ----------------------------------------------------------------------------
// msfp_pkg
// Shared constants and types for the motor status frame parser.
// ----------------------------------------------------------------------------
package msfp_pkg;

	localparam int unsigned PAYLOAD_LEN = 8;
	localparam int unsigned POS_W       = 4;
	localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

	localparam logic [7:0]       HDR_BYTE = 8'hFF;
	localparam logic [7:0]       FTR_BYTE = 8'hAA;
	localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
	localparam logic [POS_W-1:0] POS_PL1  = 4'd1;
	localparam logic [POS_W-1:0] POS_PL8  = POS_W'(PAYLOAD_LEN);
	localparam logic [POS_W-1:0] POS_FTR  = POS_W'(PAYLOAD_LEN + 1);

	// flag bit positions in the first payload byte
	localparam int unsigned FLAG_ENABLED = 0;
	localparam int unsigned FLAG_VFAULT  = 1;
	localparam int unsigned FLAG_OVHEAT  = 2;

	typedef struct packed {
		logic [7:0]         flags_raw;
		logic               enabled;
		logic               voltage_fault;
		logic               overheat;
		logic               any_fault;
		logic [7:0]         temperature;
		logic [15:0]        mech_angle;
		logic signed [15:0] rotor_speed;
		logic signed [15:0] rotor_accel;
	} msfp_status_t;

endpackage

// ===== rtl/msfp_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// msfp_frame_tracker
// Frame position counter, payload byte store and status record decode.
// ----------------------------------------------------------------------------
module msfp_frame_tracker import msfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output logic         rec_valid,
	output msfp_status_t rec
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic             store_we;
	logic             frame_done;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       store_q [PAYLOAD_LEN];

	assign wr_idx = IDX_W'(pos_q - POS_PL1);

	always_comb begin
		pos_d      = pos_q;
		store_we   = 1'b0;
		frame_done = 1'b0;
		priority if (pos_q >= POS_PL1 && pos_q <= POS_PL8) begin
			store_we = 1'b1;
			pos_d    = pos_q + POS_PL1;
		end else if (pos_q == POS_FTR) begin
			pos_d      = POS_HUNT;
			frame_done = (rx_byte == FTR_BYTE);
		end else begin
			// hunt; stray positions fall back here too
			pos_d = (pos_q == POS_HUNT && rx_byte == HDR_BYTE) ? POS_PL1 : POS_HUNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[wr_idx] <= rx_byte;
		end
	end

	assign rec_valid = step & frame_done;

	always_comb begin
		rec.flags_raw     = store_q[0];
		rec.enabled       = store_q[0][FLAG_ENABLED];
		rec.voltage_fault = store_q[0][FLAG_VFAULT];
		rec.overheat      = store_q[0][FLAG_OVHEAT];
		rec.any_fault     = store_q[0][FLAG_VFAULT] | store_q[0][FLAG_OVHEAT];
		rec.temperature   = store_q[1];
		rec.mech_angle    = {store_q[2], store_q[3]};
		rec.rotor_speed   = {store_q[4], store_q[5]};
		rec.rotor_accel   = {store_q[6], store_q[7]};
	end

endmodule

// ===== rtl/motor_status_frame_parser.sv =====
// ----------------------------------------------------------------------------
// motor_status_frame_parser
// Parses header / eight payload bytes / footer status frames from a byte
// stream and emits one decoded motor status record per good frame.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid, in_ready | rx_byte
//   out     | out_valid,out_ready| flags_raw, enabled, voltage_fault,
//           |                    | overheat, any_fault, temperature,
//           |                    | mech_angle, rotor_speed, rotor_accel
//
// One byte per cycle is taken unless the input register stalls. A byte is held
// in the input register until the tracker consumes it; a footer that matches
// loads the output register at that same edge, so a footer byte passes through
// the input register and then the output register before its record appears.
// Reset clears the position counter and both valid flags; the payload store
// holds no reset value and is always rewritten before it is read.
// The input register stalls only while the output register holds a record
// that has not been taken; otherwise bytes flow every cycle.
// ----------------------------------------------------------------------------
module motor_status_frame_parser import msfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         flags_raw,
	output logic               enabled,
	output logic               voltage_fault,
	output logic               overheat,
	output logic               any_fault,
	output logic [7:0]         temperature,
	output logic [15:0]        mech_angle,
	output logic signed [15:0] rotor_speed,
	output logic signed [15:0] rotor_accel
);

	logic         valid_s1;
	logic [7:0]   rx_byte_s1;
	logic         out_free;
	logic         advance_s1;
	logic         rec_valid;
	msfp_status_t rec;
	msfp_status_t rec_q;
	logic         out_valid_q;

	// the output register can take a record this cycle
	assign out_free   = !out_valid_q || out_ready;
	// hand the held byte to the tracker
	assign advance_s1 = valid_s1 && out_free;
	assign in_ready   = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	msfp_frame_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.rx_byte   (rx_byte_s1),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// load a finished record, drop the flag once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid) begin
			rec_q <= rec;
		end
	end

	assign out_valid     = out_valid_q;
	assign flags_raw     = rec_q.flags_raw;
	assign enabled       = rec_q.enabled;
	assign voltage_fault = rec_q.voltage_fault;
	assign overheat      = rec_q.overheat;
	assign any_fault     = rec_q.any_fault;
	assign temperature   = rec_q.temperature;
	assign mech_angle    = rec_q.mech_angle;
	assign rotor_speed   = rec_q.rotor_speed;
	assign rotor_accel   = rec_q.rotor_accel;

endmodule

// ===== dv/msfp_checker.sv =====
// ----------------------------------------------------------------------------
// msfp_checker
// Watches both channels of the motor status frame parser, tracks frame
// position and payload bytes for every byte request taken, and compares each
// status record leaving the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module msfp_checker import msfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         flags_raw,
	input  logic               enabled,
	input  logic               voltage_fault,
	input  logic               overheat,
	input  logic               any_fault,
	input  logic [7:0]         temperature,
	input  logic [15:0]        mech_angle,
	input  logic signed [15:0] rotor_speed,
	input  logic signed [15:0] rotor_accel,
	output int                 errors,
	output int                 pending,
	output int                 records_checked,
	output int                 frames_dropped
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [POS_W-1:0] frame_pos;
	logic [7:0]       payload_bytes [PAYLOAD_LEN];
	msfp_status_t     status_q [$];

	function automatic msfp_status_t decode_status();
		msfp_status_t s;
		s.flags_raw     = payload_bytes[0];
		s.enabled       = payload_bytes[0][FLAG_ENABLED];
		s.voltage_fault = payload_bytes[0][FLAG_VFAULT];
		s.overheat      = payload_bytes[0][FLAG_OVHEAT];
		s.any_fault     = payload_bytes[0][FLAG_VFAULT] | payload_bytes[0][FLAG_OVHEAT];
		s.temperature   = payload_bytes[1];
		s.mech_angle    = {payload_bytes[2], payload_bytes[3]};
		s.rotor_speed   = {payload_bytes[4], payload_bytes[5]};
		s.rotor_accel   = {payload_bytes[6], payload_bytes[7]};
		return s;
	endfunction

	task automatic compare_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%04h, got 0x%04h", $time, fname, want, got);
		end
	endtask

	// advance the frame tracker on each byte request taken
	always @(posedge clk or negedge arst_n) begin
		msfp_status_t want;
		logic [IDX_W-1:0] idx;
		if (!arst_n) begin
			frame_pos = POS_HUNT;
			status_q.delete();
			errors = 0;
			records_checked = 0;
			frames_dropped = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (frame_pos >= POS_PL1 && frame_pos <= POS_PL8) begin
					idx = IDX_W'(frame_pos - POS_PL1);
					payload_bytes[idx] = rx_byte;
					frame_pos = frame_pos + POS_PL1;
				end else if (frame_pos == POS_FTR) begin
					frame_pos = POS_HUNT;
					if (rx_byte == FTR_BYTE)
						status_q.push_back(decode_status());
					else
						frames_dropped++;
				end else begin
					frame_pos = (frame_pos == POS_HUNT && rx_byte == HDR_BYTE) ? POS_PL1 : POS_HUNT;
				end
			end
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t: record with no frame behind it, flags 0x%02h angle 0x%04h",
						$time, flags_raw, mech_angle);
				end else begin
					want = status_q.pop_front();
					compare_field("flags_raw", 16'(want.flags_raw), 16'(flags_raw));
					compare_field("enabled", 16'(want.enabled), 16'(enabled));
					compare_field("voltage_fault", 16'(want.voltage_fault), 16'(voltage_fault));
					compare_field("overheat", 16'(want.overheat), 16'(overheat));
					compare_field("any_fault", 16'(want.any_fault), 16'(any_fault));
					compare_field("temperature", 16'(want.temperature), 16'(temperature));
					compare_field("mech_angle", want.mech_angle, mech_angle);
					compare_field("rotor_speed", want.rotor_speed, rotor_speed);
					compare_field("rotor_accel", want.rotor_accel, rotor_accel);
					records_checked++;
				end
			end
		end
		pending = status_q.size();
	end

endmodule

// ===== dv/tb_motor_status_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_motor_status_frame_parser
// Drives byte streams into the motor status frame parser: a short directed
// run over the corner cases, then mostly well-formed frames with random
// content mixed with line noise, bad footers and cut-short frames. Both
// channels idle in random bursts. The checker beside the block predicts and
// compares every record; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_motor_status_frame_parser import msfp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1750;
	localparam int CALM_TAIL   = 200;      // last stretch runs without idling
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_TICKS = 10;       // extra wait once nothing is pending

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         flags_raw;
	logic               enabled;
	logic               voltage_fault;
	logic               overheat;
	logic               any_fault;
	logic [7:0]         temperature;
	logic [15:0]        mech_angle;
	logic signed [15:0] rotor_speed;
	logic signed [15:0] rotor_accel;

	int errors;
	int pending;
	int records_checked;
	int frames_dropped;
	int bytes_sent;
	int cycles;
	bit idle_on;   // cleared for stretches with no idling on either side
	bit calm;      // set for the tail of the run

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	motor_status_frame_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.flags_raw     (flags_raw),
		.enabled       (enabled),
		.voltage_fault (voltage_fault),
		.overheat      (overheat),
		.any_fault     (any_fault),
		.temperature   (temperature),
		.mech_angle    (mech_angle),
		.rotor_speed   (rotor_speed),
		.rotor_accel   (rotor_accel)
	);

	msfp_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.flags_raw       (flags_raw),
		.enabled         (enabled),
		.voltage_fault   (voltage_fault),
		.overheat        (overheat),
		.any_fault       (any_fault),
		.temperature     (temperature),
		.mech_angle      (mech_angle),
		.rotor_speed     (rotor_speed),
		.rotor_accel     (rotor_accel),
		.errors          (errors),
		.pending         (pending),
		.records_checked (records_checked),
		.frames_dropped  (frames_dropped)
	);

	// Present one byte and hold it until the request is taken. An optional idle
	// burst goes first. in_ready is read at the falling edge, where it has
	// settled, so the rising edge that follows is the one that takes the byte.
	task automatic send_byte(input logic [7:0] b);
		bit took;
		if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		bytes_sent++;
	endtask

	// Payload content leans on the edges of each field: zero, all ones, the
	// sign boundary either way and the footer value sitting inside the payload.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			4: return FTR_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input logic [7:0] footer);
		send_byte(HDR_BYTE);
		repeat (PAYLOAD_LEN) send_byte(pick_byte());
		send_byte(footer);
	endtask

	// Hold off the receiver in random bursts.
	always @(posedge clk) begin
		int stall_left;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 4) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Cap the run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records still owed", cycles, pending);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] bad_footer;
		int kind;
		idle_on = 1'b1;
		calm    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray bytes while hunting, footer value out of place
		send_byte(8'h00);
		send_byte(FTR_BYTE);
		// all-zero payload closed by a footer one bit off: drop it silently
		send_byte(HDR_BYTE);
		repeat (PAYLOAD_LEN) send_byte(8'h00);
		send_byte(8'hAB);
		// header value inside the payload is plain data; speed at its most
		// negative, acceleration at its most positive, every flag set
		send_byte(HDR_BYTE);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'hFF);
		send_byte(FTR_BYTE);

		// random: mostly good frames, mixed with noise, bad footers and cut frames
		while (bytes_sent < ITEM_TARGET) begin
			idle_on = ($urandom_range(0, 3) != 0);
			calm    = (bytes_sent > ITEM_TARGET - CALM_TAIL);
			kind    = $urandom_range(0, 9);
			if (kind < 7) begin
				send_frame(FTR_BYTE);
			end else if (kind == 7) begin
				do bad_footer = 8'($urandom_range(0, 255)); while (bad_footer == FTR_BYTE);
				send_frame(bad_footer);
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// cut short: whatever follows is swallowed as payload
				send_byte(HDR_BYTE);
				repeat ($urandom_range(0, PAYLOAD_LEN - 1)) send_byte(pick_byte());
			end
		end
		in_valid <= 1'b0;

		// drain: let the checker catch up, then wait out the output latency
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("sent %0d bytes; %0d status records checked, %0d frames dropped on footer",
			bytes_sent, records_checked, frames_dropped);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
